FILE: design/swcfg_pkg.sv
// Shared types, constants and codes of the sync word correlator frame gate.
package swcfg_pkg;

    // Defaults of the top level parameters
    localparam int HISTORY_DEPTH_DEF = 40;
    localparam int SAMPLE_WIDTH_DEF  = 16;

    // Fixed field widths
    localparam int FRAME_LEN_W = 16;
    localparam int SYNC_LEN_W  = 6;
    localparam int PATTERN_W   = 64;
    localparam int SCORE_W     = 23;
    localparam int HUNT_W      = 24;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;

    // Result side-band: frame_start, sync_score, skip_valid, skip_count
    localparam int TUSER_FIELDS_W = 1 + SCORE_W + 1 + HUNT_W;
    localparam int TUSER_W        = ((TUSER_FIELDS_W + 7) / 8) * 8;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 23'sh3FFFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 23'sh400000;
    localparam logic [HUNT_W-1:0]         HUNT_MAX  = 24'hFFFFFF;

    // Register reset values
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 16'd1;
    localparam logic [SYNC_LEN_W-1:0]  SYNC_LEN_RST  = 6'd20;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LENGTH     = 4'd0,
        REG_SYNC_LENGTH      = 4'd1,
        REG_SYNC_PATTERN     = 4'd2,
        REG_DETECT_THRESHOLD = 4'd3
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_CORR_START,
        ST_CORR,
        ST_SAT,
        ST_DECIDE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // store the transferred symbol in the history
        logic corr_start;  // bump hunt count, clear accumulator, latch window
        logic corr_step;   // read one tap and accumulate the previous one
        logic sat;         // saturate the accumulator into the score
        logic decide;      // compare score with threshold, open a frame
        logic emit;        // load the output register with the symbol
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic frame_active;  // frame symbols still to forward
        logic corr_done;     // all taps read and accumulated
        logic out_free;      // output register can take a result
    } status_t;

endpackage

FILE: design/swcfg_ctrl.sv
// Controller state machine of the sync word correlator frame gate.
module swcfg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  swcfg_pkg::status_t status,
    output swcfg_pkg::cmd_t    cmd
);
    import swcfg_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.frame_active ? ST_EMIT : ST_CORR_START;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CORR_START: state_next = ST_CORR;
            ST_CORR: begin
                if (status.corr_done) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_EMIT:       cmd.emit       = status.out_free;
            ST_CORR_START: cmd.corr_start = 1'b1;
            ST_CORR:       cmd.corr_step  = !status.corr_done;
            ST_SAT:        cmd.sat        = 1'b1;
            ST_DECIDE:     cmd.decide     = 1'b1;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/swcfg_datapath.sv
// Datapath: history memory, serial correlator, frame counters and output register.
module swcfg_datapath #(
    parameter int HISTORY_DEPTH = swcfg_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_WIDTH  = swcfg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  swcfg_pkg::cmd_t                      cmd,
    output swcfg_pkg::status_t                   status,
    input  logic                                 cfg_we,
    input  logic [swcfg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swcfg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]       in_i,
    input  logic signed [SAMPLE_WIDTH-1:0]       in_q,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic signed [SAMPLE_WIDTH-1:0]       out_i,
    output logic signed [SAMPLE_WIDTH-1:0]       out_q,
    output logic                                 frame_start,
    output logic signed [swcfg_pkg::SCORE_W-1:0] sync_score,
    output logic                                 skip_valid,
    output logic [swcfg_pkg::HUNT_W-1:0]         skip_count
);
    import swcfg_pkg::*;

    localparam int PTR_W     = $clog2(HISTORY_DEPTH);
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int WIN_EXT_W = SYNC_LEN_W + 1;
    localparam int ACC_W     = SAMPLE_WIDTH + $clog2(HISTORY_DEPTH) + 3;
    localparam int EXT_W     = (ACC_W > SCORE_W) ? ACC_W : SCORE_W;
    localparam logic [PTR_W-1:0]     LAST_PTR  = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [WIN_EXT_W-1:0] DEPTH_EXT = WIN_EXT_W'(HISTORY_DEPTH);

    // Configuration registers
    logic [FRAME_LEN_W-1:0]    frame_length_reg;
    logic [SYNC_LEN_W-1:0]     sync_length_reg;
    logic [PATTERN_W-1:0]      sync_pattern_reg;
    logic signed [SCORE_W-1:0] threshold_reg;

    // History memory with per-entry valid bits (invalid reads as zero)
    logic [2*SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]  hist_vld_reg;
    logic [PTR_W-1:0]          newest_ptr_reg;
    logic [PTR_W-1:0]          newest_ptr_next;
    logic [2*SAMPLE_WIDTH-1:0] rd_data_reg;
    logic                      rd_vld_reg;

    // Transferred symbol, held for the output register
    logic signed [SAMPLE_WIDTH-1:0] in_i_hold_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_q_hold_reg;

    // Correlator state
    logic [PTR_W-1:0]          rd_ptr_reg;
    logic [CNT_W-1:0]          tap_cnt_reg;
    logic [CNT_W-1:0]          win_reg;
    logic                      pipe_vld_reg;
    logic [PATTERN_W-1:0]      pat_sh_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [SCORE_W-1:0] score_reg;

    // Frame state
    logic [FRAME_LEN_W-1:0]    frame_remaining_reg;
    logic [HUNT_W-1:0]         hunt_count_reg;
    logic                      pending_start_reg;
    logic signed [SCORE_W-1:0] pending_score_reg;
    logic                      pending_skip_vld_reg;
    logic [HUNT_W-1:0]         pending_skip_cnt_reg;

    // Output register
    logic                      m_tvalid_reg;

    logic [WIN_EXT_W-1:0]      sl_ext;
    logic [CNT_W-1:0]          win;
    logic                      issue;
    logic signed [SAMPLE_WIDTH-1:0] tap_i;
    logic signed [SAMPLE_WIDTH-1:0] tap_q;
    logic signed [ACC_W-1:0]   tap_i_ext;
    logic signed [ACC_W-1:0]   tap_q_ext;
    logic signed [EXT_W-1:0]   acc_ext;
    logic signed [SCORE_W-1:0] score_sat;
    logic                      hit;
    logic [HUNT_W-1:0]         win_hunt;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= FRAME_LEN_RST;
            sync_length_reg  <= SYNC_LEN_RST;
            sync_pattern_reg <= '0;
            threshold_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_LENGTH:     frame_length_reg <= cfg_data[FRAME_LEN_W-1:0];
                REG_SYNC_LENGTH:      sync_length_reg  <= cfg_data[SYNC_LEN_W-1:0];
                REG_SYNC_PATTERN:     sync_pattern_reg <= cfg_data[PATTERN_W-1:0];
                REG_DETECT_THRESHOLD: threshold_reg    <= cfg_data[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    // Window length clipped to the history depth
    assign sl_ext = {1'b0, sync_length_reg};
    assign win    = (sl_ext > DEPTH_EXT) ? CNT_W'(DEPTH_EXT) : CNT_W'(sl_ext);

    // Advance the write pointer with wrap
    assign newest_ptr_next = (newest_ptr_reg == LAST_PTR) ? '0 : newest_ptr_reg + 1'b1;

    // History write pointer and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_ptr_reg <= '0;
            hist_vld_reg   <= '0;
        end else if (cmd.accept) begin
            newest_ptr_reg               <= newest_ptr_next;
            hist_vld_reg[newest_ptr_next] <= 1'b1;
        end
    end

    // History memory write and registered tap read
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            hist_mem[newest_ptr_next] <= {in_q, in_i};
        end
        if (issue) begin
            rd_data_reg <= hist_mem[rd_ptr_reg];
            rd_vld_reg  <= hist_vld_reg[rd_ptr_reg];
        end
    end

    // Hold the transferred symbol until it is forwarded
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_i_hold_reg <= in_i;
            in_q_hold_reg <= in_q;
        end
    end

    // Accumulate one tap: pattern bit 0 signs Q, bit 1 signs I
    assign issue     = cmd.corr_step && (tap_cnt_reg != win_reg);
    assign tap_i     = rd_vld_reg ? rd_data_reg[SAMPLE_WIDTH-1:0] : '0;
    assign tap_q     = rd_vld_reg ? rd_data_reg[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : '0;
    assign tap_i_ext = ACC_W'(tap_i);
    assign tap_q_ext = ACC_W'(tap_q);
    assign acc_next  = acc_reg
                     + (pat_sh_reg[1] ? tap_i_ext : -tap_i_ext)
                     + (pat_sh_reg[0] ? tap_q_ext : -tap_q_ext);

    // Serial correlator control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_cnt_reg  <= '0;
            win_reg      <= '0;
            pipe_vld_reg <= 1'b0;
        end else if (cmd.corr_start) begin
            tap_cnt_reg  <= '0;
            win_reg      <= win;
            pipe_vld_reg <= 1'b0;
        end else if (cmd.corr_step) begin
            pipe_vld_reg <= issue;
            if (issue) begin
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
            end
        end
    end

    // Correlator data path
    always_ff @(posedge aclk) begin
        if (cmd.corr_start) begin
            rd_ptr_reg <= newest_ptr_reg;
            acc_reg    <= '0;
            pat_sh_reg <= sync_pattern_reg;
        end else if (cmd.corr_step) begin
            if (issue) begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_PTR : rd_ptr_reg - 1'b1;
            end
            if (pipe_vld_reg) begin
                acc_reg    <= acc_next;
                pat_sh_reg <= {2'b00, pat_sh_reg[PATTERN_W-1:2]};
            end
        end
        if (cmd.sat) begin
            score_reg <= score_sat;
        end
    end

    // Saturate the sum to the score range
    assign acc_ext = EXT_W'(acc_reg);
    always_comb begin
        priority if (acc_ext > EXT_W'(SCORE_MAX)) begin
            score_sat = SCORE_MAX;
        end else if (acc_ext < EXT_W'(SCORE_MIN)) begin
            score_sat = SCORE_MIN;
        end else begin
            score_sat = SCORE_W'(acc_ext);
        end
    end

    assign hit      = score_reg > threshold_reg;
    assign win_hunt = HUNT_W'(win_reg);

    // Hunt count, frame counter and pending start mark
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_remaining_reg  <= '0;
            hunt_count_reg       <= '0;
            pending_start_reg    <= 1'b0;
            pending_score_reg    <= '0;
            pending_skip_vld_reg <= 1'b0;
            pending_skip_cnt_reg <= '0;
        end else begin
            if (cmd.corr_start && (hunt_count_reg != HUNT_MAX)) begin
                hunt_count_reg <= hunt_count_reg + 1'b1;
            end
            if (cmd.decide && hit) begin
                pending_start_reg    <= 1'b1;
                pending_score_reg    <= score_reg;
                pending_skip_vld_reg <= hunt_count_reg > win_hunt;
                pending_skip_cnt_reg <= (hunt_count_reg > win_hunt)
                                      ? hunt_count_reg - win_hunt : '0;
                hunt_count_reg       <= '0;
                frame_remaining_reg  <= frame_length_reg;
            end
            if (cmd.emit) begin
                pending_start_reg    <= 1'b0;
                pending_score_reg    <= '0;
                pending_skip_vld_reg <= 1'b0;
                pending_skip_cnt_reg <= '0;
                frame_remaining_reg  <= frame_remaining_reg - 1'b1;
            end
        end
    end

    // Output valid: set on load, drop when the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_i       <= in_i_hold_reg;
            out_q       <= in_q_hold_reg;
            frame_start <= pending_start_reg;
            sync_score  <= pending_score_reg;
            skip_valid  <= pending_skip_vld_reg;
            skip_count  <= pending_skip_cnt_reg;
        end
    end

    assign m_tvalid            = m_tvalid_reg;
    assign status.frame_active = frame_remaining_reg != '0;
    assign status.corr_done    = (tap_cnt_reg == win_reg) && !pipe_vld_reg;
    assign status.out_free     = !m_tvalid_reg || m_tready;

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken result");
    a_tap_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_cnt_reg <= win_reg)
        else $error("tap count ran past the window");
    a_skip_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_skip_vld_reg |-> pending_start_reg)
        else $error("skip mark without start mark");
    a_plain_symbol_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !frame_start) |-> (sync_score == '0 && !skip_valid
                                             && skip_count == '0))
        else $error("side-band set on a symbol without frame start");
`endif

endmodule

FILE: design/sync_word_correlator_frame_gate.sv
// Top level of the sync word correlator frame gate.
// Usage:
//   s_ channel: one complex soft symbol per transfer, s_tdata = {q, i}.
//   m_ channel: forwarded frame symbols, m_tuser side-band marks the first
//   symbol of a frame with its score and the symbols skipped while hunting.
//   cfg channel: register writes (0 frame_length, 1 sync_length,
//   2 sync_pattern, 3 detect_threshold), always ready; write only when idle.
// Timing:
//   While a frame is open a symbol is taken in the transfer cycle and then
//   loaded into the output register in ST_EMIT, which waits while the
//   register holds an untaken result; m_tvalid is registered on that load.
//   While hunting a symbol runs ST_CORR_START, ST_CORR, ST_SAT, ST_DECIDE;
//   ST_CORR makes a serial pass over the window W (sync_length clipped to
//   HISTORY_DEPTH), one tap read per cycle. Hunted symbols give no result.
// Reset (aresetn low, synchronous) clears the history to zero, the hunt and
// frame counters, the pending start mark and the output valid, and loads the
// register defaults. A stalled receiver holds the result in the output
// register; hunted symbols are still taken, and the next frame symbol is
// taken and waits for the slot with s_tready low.
module sync_word_correlator_frame_gate #(
    parameter int HISTORY_DEPTH = swcfg_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_WIDTH  = swcfg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sample_i, sample_q
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_i, out_q
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  m_tdata,
    // frame_start, sync_score, skip_valid, skip_count
    output logic [swcfg_pkg::TUSER_W-1:0]        m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swcfg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swcfg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import swcfg_pkg::*;

    localparam int TDATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;

    cmd_t    cmd;
    status_t status;

    logic signed [SAMPLE_WIDTH-1:0] out_i;
    logic signed [SAMPLE_WIDTH-1:0] out_q;
    logic                           frame_start;
    logic signed [SCORE_W-1:0]      sync_score;
    logic                           skip_valid;
    logic [HUNT_W-1:0]              skip_count;

    assign cfg_ready = 1'b1;

    swcfg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swcfg_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_i        (s_tdata[SAMPLE_WIDTH-1:0]),
        .in_q        (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_i       (out_i),
        .out_q       (out_q),
        .frame_start (frame_start),
        .sync_score  (sync_score),
        .skip_valid  (skip_valid),
        .skip_count  (skip_count)
    );

    // Pack result fields, lowest field first, zero filled
    assign m_tdata = TDATA_W'({out_q, out_i});
    assign m_tuser = TUSER_W'({skip_count, skip_valid, sync_score, frame_start});

endmodule
